[rtl/lrc_pkg.sv]
package lrc_pkg;

   // slot count, derived index width and field widths
   localparam int SLOTS   = 4;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_W  = 4;
   localparam int REG_W   = 5;
   localparam int STAMP_W = 16;
   localparam int KIND_W  = 2;
   localparam int ACT_W   = 2;
   localparam int MODE_W  = 2;

   // slot kinds
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIRTY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TEMP  = 2'd3;

   // request actions
   localparam logic [ACT_W-1:0] ACT_GET   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TEMP  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

   // access modes
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;

   // running result of the slot scan
   typedef struct packed {
      logic             hit_found;
      logic [IDX_W-1:0] hit_idx;
      logic             hit_dirty;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             vic_found;
      logic [IDX_W-1:0] vic_idx;
      logic             vic_dirty;
      logic [STAMP_W-1:0] vic_stamp;
   } scan_acc_type;

   // write command into the slot file
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [KIND_W-1:0]  kind;
      logic               set_tag;
      logic [REG_W-1:0]   greg;
      logic [STAMP_W-1:0] stamp;
   } slot_wr_type;

endpackage

[rtl/lrc_scan_unit.sv]
module lrc_scan_unit (
   input  lrc_pkg::scan_acc_type          acc_i,
   input  logic [lrc_pkg::IDX_W-1:0]      idx,
   input  logic [lrc_pkg::KIND_W-1:0]     kind,
   input  logic [lrc_pkg::REG_W-1:0]      greg,
   input  logic [lrc_pkg::STAMP_W-1:0]    stamp,
   input  logic [lrc_pkg::REG_W-1:0]      req_reg,
   input  logic                           lowest_free,
   output lrc_pkg::scan_acc_type          acc_o
);
   import lrc_pkg::*;

   logic cached;

   // one slot per call: tag compare, free pick and stamp compare
   always_comb begin
      cached = (kind == KIND_CLEAN) || (kind == KIND_DIRTY);
      acc_o  = acc_i;
      if (cached && (greg == req_reg) && !acc_i.hit_found) begin
         acc_o.hit_found = 1'b1;
         acc_o.hit_idx   = idx;
         acc_o.hit_dirty = (kind == KIND_DIRTY);
      end
      if ((kind == KIND_FREE) && (lowest_free || !acc_i.free_found)) begin
         acc_o.free_found = 1'b1;
         acc_o.free_idx   = idx;
      end
      // scan runs downwards, so a strict compare keeps the higher index on ties
      if (cached && (!acc_i.vic_found || (stamp < acc_i.vic_stamp))) begin
         acc_o.vic_found = 1'b1;
         acc_o.vic_idx   = idx;
         acc_o.vic_dirty = (kind == KIND_DIRTY);
         acc_o.vic_stamp = stamp;
      end
   end

endmodule

[rtl/lrc_slot_file.sv]
module lrc_slot_file (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lrc_pkg::IDX_W-1:0]       rd_idx,
   output logic [lrc_pkg::KIND_W-1:0]      rd_kind,
   output logic [lrc_pkg::REG_W-1:0]       rd_greg,
   output logic [lrc_pkg::STAMP_W-1:0]     rd_stamp,
   output logic [lrc_pkg::SLOTS-1:0]       dirty_vec,
   input  lrc_pkg::slot_wr_type            wr
);
   import lrc_pkg::*;

   logic [KIND_W-1:0]  kind_ff  [SLOTS];
   logic [REG_W-1:0]   greg_ff  [SLOTS];
   logic [STAMP_W-1:0] stamp_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            kind_ff[i] <= KIND_FREE;
         end
      end else if (wr.en) begin
         kind_ff[wr.idx] <= wr.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.set_tag) begin
         greg_ff[wr.idx]  <= wr.greg;
         stamp_ff[wr.idx] <= wr.stamp;
      end
   end

   always_comb begin
      rd_kind  = kind_ff[rd_idx];
      rd_greg  = greg_ff[rd_idx];
      rd_stamp = stamp_ff[rd_idx];
      for (int i = 0; i < SLOTS; i++) begin
         dirty_vec[i] = (kind_ff[i] == KIND_DIRTY);
      end
   end

endmodule

[rtl/lru_register_cache_allocator.sv]
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_action, req_guest_reg, req_access_mode
// rsp       out        rsp_valid/rsp_stall  rsp_slot, rsp_load_valid, rsp_load_reg,
//                                           rsp_writeback_valid, rsp_writeback_reg,
//                                           rsp_error, rsp_last
//
// a get or temp request walks the slots one per cycle through a single compare unit,
// from the top slot down, then waits in the grant state for a free output register
// a flush goes up a slot per cycle, dirty ones wait on rsp; empty item if none dirty
// reset clears the sequencer, the output valid bit, the counter and every slot kind
// req_stall is high whenever the sequencer is busy; a new request may be taken while
// a result still waits in the output register, and a stalled rsp holds the sequencer
// only where it has a further item to deliver
module lru_register_cache_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lrc_pkg::ACT_W-1:0]       req_action,
   input  logic [lrc_pkg::REG_W-1:0]       req_guest_reg,
   input  logic [lrc_pkg::MODE_W-1:0]      req_access_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lrc_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                            rsp_load_valid,
   output logic [lrc_pkg::REG_W-1:0]       rsp_load_reg,
   output logic                            rsp_writeback_valid,
   output logic [lrc_pkg::REG_W-1:0]       rsp_writeback_reg,
   output logic                            rsp_error,
   output logic                            rsp_last
);
   import lrc_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SCAN      = 3'd1;
   localparam logic [2:0] ST_GRANT     = 3'd2;
   localparam logic [2:0] ST_FLUSH     = 3'd3;
   localparam logic [2:0] ST_FLUSH_END = 3'd4;

   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(SLOTS - 1);

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ACT_W-1:0]   act_ff, act_in;
   logic [REG_W-1:0]   reg_ff, reg_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic               any_ff, any_in;
   scan_acc_type       acc_ff, acc_in, acc_step;

   // register held by the current victim candidate, tracked beside the scan
   logic [REG_W-1:0]   vic_greg_ff, vic_greg_in;

   // output register
   logic               out_valid_ff;
   logic [SLOT_W-1:0]  out_slot_ff;
   logic               out_lv_ff, out_wv_ff, out_err_ff, out_last_ff;
   logic [REG_W-1:0]   out_lr_ff, out_wr_ff;

   logic               emit;
   logic [SLOT_W-1:0]  e_slot;
   logic               e_lv, e_wv, e_err, e_last;
   logic [REG_W-1:0]   e_lr, e_wr;

   logic               out_free, req_xfer;
   logic [KIND_W-1:0]  rd_kind;
   logic [REG_W-1:0]   rd_greg;
   logic [STAMP_W-1:0] rd_stamp;
   logic [SLOTS-1:0]   dirty_vec;
   logic               dirty_above;
   slot_wr_type        wr;
   logic [IDX_W-1:0]   tgt;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   lrc_slot_file u_slots (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (idx_ff),
      .rd_kind   (rd_kind),
      .rd_greg   (rd_greg),
      .rd_stamp  (rd_stamp),
      .dirty_vec (dirty_vec),
      .wr        (wr)
   );

   lrc_scan_unit u_scan (
      .acc_i       (acc_ff),
      .idx         (idx_ff),
      .kind        (rd_kind),
      .greg        (rd_greg),
      .stamp       (rd_stamp),
      .req_reg     (reg_ff),
      .lowest_free (act_ff == ACT_TEMP),
      .acc_o       (acc_step)
   );

   // is any slot above the current flush position still dirty
   always_comb begin
      dirty_above = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if (dirty_vec[j] && (j > int'(idx_ff))) begin
            dirty_above = 1'b1;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      act_in     = act_ff;
      reg_in     = reg_ff;
      mode_in    = mode_ff;
      counter_in = counter_ff;
      any_in     = any_ff;
      acc_in     = acc_ff;
      emit       = 1'b0;
      e_slot     = '0;
      e_lv       = 1'b0;
      e_lr       = '0;
      e_wv       = 1'b0;
      e_wr       = '0;
      e_err      = 1'b0;
      e_last     = 1'b1;
      wr         = '0;
      tgt        = acc_ff.free_idx;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               act_in  = req_action;
               reg_in  = req_guest_reg;
               mode_in = req_access_mode;
               acc_in  = '0;
               any_in  = 1'b0;
               case (req_action)
                  ACT_GET: begin
                     counter_in = counter_ff + STAMP_W'(1);
                     idx_in     = IDX_TOP;
                     state_in   = ST_SCAN;
                  end
                  ACT_TEMP: begin
                     idx_in   = IDX_TOP;
                     state_in = ST_SCAN;
                  end
                  ACT_FLUSH: begin
                     counter_in = '0;
                     idx_in     = '0;
                     state_in   = ST_FLUSH;
                  end
                  default: begin
                     // unused action: taken and dropped
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            acc_in = acc_step;
            if (idx_ff == '0) begin
               state_in = ST_GRANT;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end

         ST_GRANT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if ((act_ff == ACT_GET) && acc_ff.hit_found) begin
                  // hit: restamp, dirty unless a read of a clean slot
                  wr.en      = 1'b1;
                  wr.idx     = acc_ff.hit_idx;
                  wr.kind    = ((mode_ff != MODE_READ) || acc_ff.hit_dirty) ?
                               KIND_DIRTY : KIND_CLEAN;
                  wr.set_tag = 1'b1;
                  wr.greg    = reg_ff;
                  wr.stamp   = counter_ff;
                  e_slot     = SLOT_W'(acc_ff.hit_idx);
               end else if (!acc_ff.free_found && !acc_ff.vic_found) begin
                  e_err = 1'b1;
               end else begin
                  if (!acc_ff.free_found) begin
                     tgt  = acc_ff.vic_idx;
                     e_wv = acc_ff.vic_dirty;
                     e_wr = acc_ff.vic_dirty ? vic_greg_ff : '0;
                  end
                  e_slot = SLOT_W'(tgt);
                  wr.en  = 1'b1;
                  wr.idx = tgt;
                  if (act_ff == ACT_TEMP) begin
                     wr.kind = KIND_TEMP;
                  end else begin
                     wr.kind    = (mode_ff != MODE_READ) ? KIND_DIRTY : KIND_CLEAN;
                     wr.set_tag = 1'b1;
                     wr.greg    = reg_ff;
                     wr.stamp   = counter_ff;
                     e_lv       = (mode_ff != MODE_WRITE);
                     e_lr       = (mode_ff != MODE_WRITE) ? reg_ff : '0;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (rd_kind != KIND_DIRTY || out_free) begin
               wr.en   = 1'b1;
               wr.idx  = idx_ff;
               wr.kind = KIND_FREE;
               if (rd_kind == KIND_DIRTY) begin
                  emit   = 1'b1;
                  e_slot = SLOT_W'(idx_ff);
                  e_wv   = 1'b1;
                  e_wr   = rd_greg;
                  e_last = !dirty_above;
                  any_in = 1'b1;
               end
               if (idx_ff == IDX_TOP) begin
                  state_in = (any_ff || (rd_kind == KIND_DIRTY)) ? ST_IDLE : ST_FLUSH_END;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end

         ST_FLUSH_END: begin
            // no dirty slot: a single empty closing transfer
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      vic_greg_in = vic_greg_ff;
      if (state_ff == ST_SCAN && acc_step.vic_found &&
          (!acc_ff.vic_found || acc_step.vic_idx != acc_ff.vic_idx)) begin
         vic_greg_in = rd_greg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         counter_ff <= counter_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      act_ff      <= act_in;
      reg_ff      <= reg_in;
      mode_ff     <= mode_in;
      any_ff      <= any_in;
      acc_ff      <= acc_in;
      vic_greg_ff <= vic_greg_in;
      if (emit) begin
         out_slot_ff <= e_slot;
         out_lv_ff   <= e_lv;
         out_lr_ff   <= e_lr;
         out_wv_ff   <= e_wv;
         out_wr_ff   <= e_wr;
         out_err_ff  <= e_err;
         out_last_ff <= e_last;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_slot            = out_slot_ff;
   assign rsp_load_valid      = out_lv_ff;
   assign rsp_load_reg        = out_lr_ff;
   assign rsp_writeback_valid = out_wv_ff;
   assign rsp_writeback_reg   = out_wr_ff;
   assign rsp_error           = out_err_ff;
   assign rsp_last            = out_last_ff;

endmodule
